@@ rtl/crc64_byte_update_macros.svh @@
// assertion macros used by the crc64 checker file
`ifndef CRC64_BYTE_UPDATE_MACROS_SVH
`define CRC64_BYTE_UPDATE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CRC64_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CRC64_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/crc64_pkg.sv @@
// shared constants, csr map and crc table functions for the crc64 byte updater
package crc64_pkg;

   localparam int CRC_WIDTH      = 64;
   localparam int BYTE_WIDTH     = 8;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int REG_IDX_LSB    = 3;
   localparam int REG_IDX_WIDTH  = CSR_ADDR_WIDTH - REG_IDX_LSB;

   typedef logic [CRC_WIDTH-1:0]      crc_type;
   typedef logic [BYTE_WIDTH-1:0]     byte_type;
   typedef logic [REG_IDX_WIDTH-1:0]  reg_idx_type;

   localparam reg_idx_type REG_SEED = reg_idx_type'(0);

   localparam crc_type BASIS [BYTE_WIDTH] = '{
      64'h24854997ba2f81e7, 64'h490a932f745f03ce,
      64'h9215265ee8be079c, 64'h66daad56789639ab,
      64'hcdb55aacf12c7356, 64'hd99a54b24bb2d03f,
      64'hf1c4488f3e8f96ed, 64'ha17870f5d4f51b49
   };

   function automatic crc_type table_entry(input byte_type idx);
      crc_type acc;
      acc = '0;
      for (int b = 0; b < BYTE_WIDTH; b++) begin
         if (idx[b]) begin
            acc = acc ^ BASIS[b];
         end
      end
      return acc;
   endfunction

   function automatic crc_type crc_update(input crc_type crc, input byte_type data);
      byte_type idx;
      idx = crc[BYTE_WIDTH-1:0] ^ data;
      return table_entry(idx) ^ (crc >> BYTE_WIDTH);
   endfunction

endpackage

@@ rtl/crc64_csr.sv @@
// apb register block holding the crc seed
module crc64_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [crc64_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [crc64_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [crc64_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                  pready,
   output crc64_pkg::crc_type                    seed
);

   crc64_pkg::crc_type     seed_ff;
   crc64_pkg::crc_type     seed_in;
   crc64_pkg::reg_idx_type reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[crc64_pkg::CSR_ADDR_WIDTH-1:crc64_pkg::REG_IDX_LSB];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      seed_in = seed_ff;
      if (wr_en && (reg_idx == crc64_pkg::REG_SEED)) begin
         seed_in = crc64_pkg::crc_type'(pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   always_comb begin
      case (reg_idx)
         crc64_pkg::REG_SEED: prdata = crc64_pkg::CSR_DATA_WIDTH'(seed_ff);
         default:             prdata = '0;
      endcase
   end

   assign seed = seed_ff;

endmodule

@@ rtl/crc64_byte_update.sv @@
// top level: byte-serial reflected 64-bit crc with seed register
// Usage:
//   req channel carries one message byte per transaction with first and
//   last marks; first_byte reloads the crc from the seed register before
//   the byte is folded in.
//   rsp channel returns the running crc after each byte together with the
//   byte's last mark; there is exactly one rsp transaction per req.
//   The seed is written through the apb port at byte address 0 and takes
//   effect at the next first byte; pready is always high.
// Result: registered, valid in the cycle after its req transaction.
// Throughput: one byte per cycle while rsp_ready is high, set by the single table lookup
//   and xor feeding the running crc register, which also holds the result.
// Reset (synchronous): seed and running crc clear to zero, no result pending.
// Stall: while rsp_ready is low the held result stays put and req_ready
//   drops; accepting resumes in the cycle the result is taken.
module crc64_byte_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_first_byte,
   input  logic                                  req_last_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [63:0]                           rsp_crc_value,
   output logic                                  rsp_is_final,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [crc64_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [crc64_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [crc64_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                  pready
);

   crc64_pkg::crc_type seed;
   crc64_pkg::crc_type crc_ff;
   crc64_pkg::crc_type crc_in;
   logic               valid_ff;
   logic               valid_in;
   logic               final_ff;
   logic               final_in;
   logic               req_take;
   crc64_pkg::crc_type crc_start;

   crc64_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .seed    (seed)
   );

   assign req_ready = !valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign crc_start = req_first_byte ? seed : crc_ff;

   always_comb begin
      crc_in   = crc_ff;
      final_in = final_ff;
      valid_in = valid_ff && !rsp_ready;
      if (req_take) begin
         crc_in   = crc64_pkg::crc_update(crc_start, req_data_byte);
         final_in = req_last_byte;
         valid_in = 1'b1;
      end
   end

   // crc_ff is both the running state and the result payload
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff <= final_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_crc_value = crc_ff;
   assign rsp_is_final  = final_ff;

endmodule

@@ rtl/crc64_byte_update_checker.sv @@
// port-level checker for the crc64 byte updater and its bind
`include "crc64_byte_update_macros.svh"

module crc64_byte_update_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_crc_value,
   input logic        rsp_is_final
);

   `CRC64_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_crc_value) && $stable(rsp_is_final), "stalled result changed")
   `CRC64_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid && (rsp_is_final == $past(req_last_byte)), "accepted byte gave no matching result")
   `CRC64_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input blocked with empty result register")
   `CRC64_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid, "result pending right after reset")

endmodule

bind crc64_byte_update crc64_byte_update_checker u_crc64_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_crc_value (rsp_crc_value),
   .rsp_is_final  (rsp_is_final)
);

@@ test/tb_top.sv @@
// self-checking testbench for the byte-serial crc64 updater with apb seed register
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CYCLES   = 300000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [crc64_pkg::CSR_ADDR_WIDTH-1:0] SEED_ADDR =
      crc64_pkg::CSR_ADDR_WIDTH'(crc64_pkg::REG_SEED) << crc64_pkg::REG_IDX_LSB;
   localparam logic [crc64_pkg::CSR_ADDR_WIDTH-1:0] SPARE_ADDR =
      crc64_pkg::CSR_ADDR_WIDTH'(crc64_pkg::REG_SEED + 1) << crc64_pkg::REG_IDX_LSB;
   localparam crc64_pkg::crc_type POLY_BASIS [crc64_pkg::BYTE_WIDTH] = '{
      64'h24854997ba2f81e7, 64'h490a932f745f03ce,
      64'h9215265ee8be079c, 64'h66daad56789639ab,
      64'hcdb55aacf12c7356, 64'hd99a54b24bb2d03f,
      64'hf1c4488f3e8f96ed, 64'ha17870f5d4f51b49
   };

   typedef struct {
      crc64_pkg::crc_type crc;
      logic               fin;
   } crc_result_type;

   class crc_tracker_type;
      crc64_pkg::crc_type seed_value;
      crc64_pkg::crc_type running;
      crc_result_type     pending[$];
      int                 failures;

      function new();
         seed_value = '0;
         running    = '0;
         failures   = 0;
      endfunction

      function crc64_pkg::crc_type fold_byte(crc64_pkg::crc_type crc,
                                             crc64_pkg::byte_type data);
         crc64_pkg::byte_type idx;
         crc64_pkg::crc_type  acc;
         idx = crc[crc64_pkg::BYTE_WIDTH-1:0] ^ data;
         acc = '0;
         for (int b = 0; b < crc64_pkg::BYTE_WIDTH; b++) begin
            if (idx[b]) begin
               acc = acc ^ POLY_BASIS[b];
            end
         end
         return acc ^ (crc >> crc64_pkg::BYTE_WIDTH);
      endfunction

      function void note_byte(crc64_pkg::byte_type data, logic first_b, logic last_b);
         crc_result_type r;
         running = fold_byte(first_b ? seed_value : running, data);
         r.crc = running;
         r.fin = last_b;
         pending.push_back(r);
      endfunction

      function void flag(string what, crc64_pkg::crc_type want, crc64_pkg::crc_type got);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("mismatch %s: expected %h, actual %h", what, want, got);
         end
      endfunction

      function void check_result(crc64_pkg::crc_type crc, logic fin);
         crc_result_type r;
         if (pending.size() == 0) begin
            flag("unexpected rsp transaction", '0, crc);
            return;
         end
         r = pending.pop_front();
         if (crc !== r.crc) begin
            flag("crc_value", r.crc, crc);
         end
         if (fin !== r.fin) begin
            flag("is_final", crc64_pkg::crc_type'(r.fin), crc64_pkg::crc_type'(fin));
         end
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   crc64_pkg::byte_type                  req_data_byte;
   logic                                 req_first_byte;
   logic                                 req_last_byte;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   crc64_pkg::crc_type                   rsp_crc_value;
   logic                                 rsp_is_final;
   logic                                 psel;
   logic                                 penable;
   logic                                 pwrite;
   logic [crc64_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [crc64_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [crc64_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                 pready;

   crc_tracker_type tracker = new();
   bit              no_idle = 1'b0;
   int              cycle_count = 0;

   crc64_byte_update dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_is_final   (rsp_is_final),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.note_byte(req_data_byte, req_first_byte, req_last_byte);
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_result(rsp_crc_value, rsp_is_final);
         end
      end
   end

   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input crc64_pkg::byte_type data, input logic first_b,
                            input logic last_b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_first_byte <= first_b;
      req_last_byte  <= last_b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(crc64_pkg::byte_type'($urandom), i == 0, i == len - 1);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending.size() > 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr,
                             input logic [crc64_pkg::CSR_ADDR_WIDTH-1:0] addr,
                             input crc64_pkg::crc_type data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr && addr == SEED_ADDR) begin
         tracker.seed_value = data;
      end else if (!wr && addr == SEED_ADDR && prdata !== tracker.seed_value) begin
         tracker.flag("seed readback", tracker.seed_value, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      crc64_pkg::crc_type seed;
      int                 count;
      int                 len;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_first_byte = 1'b0;
      req_last_byte  = 1'b0;
      rsp_ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes with no message started, then continuing past a last byte
      csr_access(1'b0, SEED_ADDR, '0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'ha5, 1'b0, 1'b1);
      send_byte(8'h3c, 1'b0, 1'b0);
      settle();

      // one-byte messages and walking data bits
      csr_access(1'b1, SEED_ADDR, '1);
      csr_access(1'b0, SEED_ADDR, '0);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hff, 1'b1, 1'b1);
      for (int k = 0; k < crc64_pkg::BYTE_WIDTH; k++) begin
         send_byte(crc64_pkg::byte_type'(1 << k), k == 0, k == crc64_pkg::BYTE_WIDTH - 1);
      end

      // seed changed in mid-message applies only at the next first byte
      send_byte(8'h5a, 1'b1, 1'b0);
      settle();
      csr_access(1'b1, SEED_ADDR, 64'h8000000000000001);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h22, 1'b0, 1'b1);
      send_byte(8'h33, 1'b1, 1'b1);
      settle();

      // write to an unmapped register is ignored
      csr_access(1'b1, SPARE_ADDR, {$urandom, $urandom});
      csr_access(1'b0, SEED_ADDR, '0);
      send_byte(8'h7e, 1'b1, 1'b1);

      for (int ph = 0; ph < 10; ph++) begin
         settle();
         case (ph % 5)
            0: seed = '0;
            1: seed = '1;
            2: seed = 64'h8000000000000000;
            3: seed = 64'h0000000000000001;
            default: seed = {$urandom, $urandom};
         endcase
         csr_access(1'b1, SEED_ADDR, seed);
         csr_access(1'b0, SEED_ADDR, '0);
         if (ph == 3) begin
            csr_access(1'b1, SPARE_ADDR, {$urandom, $urandom});
         end
         no_idle = (ph % 4 == 2);
         count = 0;
         while (count < 150) begin
            if ($urandom_range(0, 9) < 8) begin
               len = $urandom_range(1, 12);
               send_message(len);
               count += len;
            end else begin
               send_byte(crc64_pkg::byte_type'($urandom), logic'($urandom_range(0, 1)),
                         logic'($urandom_range(0, 1)));
               count++;
            end
         end
      end
      no_idle = 1'b0;

      settle();
      repeat (10) @(posedge clock);
      if (tracker.pending.size() != 0) begin
         tracker.flag("rsp transactions never returned",
                      crc64_pkg::crc_type'(tracker.pending.size()), '0);
      end
      if (tracker.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
